FILE: src/dwpt_pkg.sv
// ----------------------------------------------------------------------------
// dwpt_pkg
// Shared widths, configuration register map and types of the disk watermark
// pressure tracker.
// ----------------------------------------------------------------------------
package dwpt_pkg;

  localparam int DISK_W    = 6;
  localparam int BYTES_W   = 64;
  localparam int WM_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int PROD_W    = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_WM  = 2'd1;

  localparam logic [WM_W-1:0] HIGH_WM_RST = 16'd58982;
  localparam logic [WM_W-1:0] LOW_WM_RST  = 16'd52429;

  // flag write-back request from the update stage
  typedef struct packed {
    logic              en;
    logic [DISK_W-1:0] disk;
    logic              flag;
  } flag_wr_t;

endpackage

FILE: src/dwpt_report_if.sv
// ----------------------------------------------------------------------------
// dwpt_report_if
// Space report channel: one disk's usage and capacity per transaction.
// ----------------------------------------------------------------------------
interface dwpt_report_if;

  logic                         valid;
  logic                         ready;
  logic [dwpt_pkg::DISK_W-1:0]  disk_index;
  logic [dwpt_pkg::BYTES_W-1:0] used_bytes;
  logic [dwpt_pkg::BYTES_W-1:0] reserved_bytes;
  logic [dwpt_pkg::BYTES_W-1:0] capacity_bytes;

  modport source (
    output valid, disk_index, used_bytes, reserved_bytes, capacity_bytes,
    input  ready
  );

  modport sink (
    input  valid, disk_index, used_bytes, reserved_bytes, capacity_bytes,
    output ready
  );

endinterface

FILE: src/dwpt_result_if.sv
// ----------------------------------------------------------------------------
// dwpt_result_if
// Pressure result channel: flag and deficit of one disk per transaction.
// ----------------------------------------------------------------------------
interface dwpt_result_if;

  logic                         valid;
  logic                         ready;
  logic [dwpt_pkg::DISK_W-1:0]  disk_echo;
  logic                         is_pressured;
  logic                         has_deficit;
  logic [dwpt_pkg::BYTES_W-1:0] deficit_bytes;

  modport source (
    output valid, disk_echo, is_pressured, has_deficit, deficit_bytes,
    input  ready
  );

  modport sink (
    input  valid, disk_echo, is_pressured, has_deficit, deficit_bytes,
    output ready
  );

endinterface

FILE: src/dwpt_mark_unit.sv
// ----------------------------------------------------------------------------
// dwpt_mark_unit
// High and low marks: capacity times Q0.16 watermark, floored, at least 1.
// Partial products are registered; the recombination is combinational.
// ----------------------------------------------------------------------------
module dwpt_mark_unit (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [dwpt_pkg::BYTES_W-1:0] cap_i,
  input  logic [dwpt_pkg::WM_W-1:0]    high_wm_i,
  input  logic [dwpt_pkg::WM_W-1:0]    low_wm_i,
  output logic [dwpt_pkg::BYTES_W-1:0] high_mark_o,
  output logic [dwpt_pkg::BYTES_W-1:0] low_mark_o
);

  logic [dwpt_pkg::PROD_W-1:0] hi_lo_q, hi_hi_q, lo_lo_q, lo_hi_q;

  function automatic logic [dwpt_pkg::BYTES_W-1:0] combine(
    input logic [dwpt_pkg::PROD_W-1:0] p_lo,
    input logic [dwpt_pkg::PROD_W-1:0] p_hi
  );
    logic [dwpt_pkg::BYTES_W-1:0] m;
    m = {p_hi, 16'h0000} + {32'h0000_0000, p_lo[dwpt_pkg::PROD_W-1:16]};
    return (m == '0) ? 64'd1 : m;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_lo_q <= dwpt_pkg::PROD_W'(cap_i[31:0])  * dwpt_pkg::PROD_W'(high_wm_i);
      hi_hi_q <= dwpt_pkg::PROD_W'(cap_i[63:32]) * dwpt_pkg::PROD_W'(high_wm_i);
      lo_lo_q <= dwpt_pkg::PROD_W'(cap_i[31:0])  * dwpt_pkg::PROD_W'(low_wm_i);
      lo_hi_q <= dwpt_pkg::PROD_W'(cap_i[63:32]) * dwpt_pkg::PROD_W'(low_wm_i);
    end
  end

  assign high_mark_o = combine(hi_lo_q, hi_hi_q);
  assign low_mark_o  = combine(lo_lo_q, lo_hi_q);

endmodule

FILE: src/dwpt_flag_store.sv
// ----------------------------------------------------------------------------
// dwpt_flag_store
// Per-disk pressure flag memory: synchronous read at accept,
// write-back from the update stage, forwarding of the two writes that the
// read can miss, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module dwpt_flag_store #(
  parameter int DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        rd_en_i,
  input  logic [dwpt_pkg::DISK_W-1:0] rd_disk_i,
  input  logic [dwpt_pkg::DISK_W-1:0] s1_disk_i,
  input  dwpt_pkg::flag_wr_t          wr_i,
  output logic                        flag_o,
  output logic                        busy_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic               mem [DEPTH];
  logic               rd_q;
  logic               busy_q;
  logic [AW-1:0]      clr_q;
  dwpt_pkg::flag_wr_t last_q;

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= 1'b0;
    end else if (adv_i && wr_i.en) begin
      mem[wr_i.disk[AW-1:0]] <= wr_i.flag;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_disk_i[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
      last_q <= '0;
    end else begin
      if (busy_q) begin
        clr_q <= clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          busy_q <= 1'b0;
        end
      end
      if (adv_i) begin
        last_q <= wr_i;
      end
    end
  end

  always_comb begin
    priority if (wr_i.en && wr_i.disk == s1_disk_i) begin
      flag_o = wr_i.flag;
    end else if (last_q.en && last_q.disk == s1_disk_i) begin
      flag_o = last_q.flag;
    end else begin
      flag_o = rd_q;
    end
  end

  assign busy_o = busy_q;

endmodule

FILE: src/disk_watermark_pressure_tracker.sv
// ----------------------------------------------------------------------------
// disk_watermark_pressure_tracker
// Per-disk high/low watermark hysteresis on space reports.
//
//   channel    dir  handshake     payload
//   report_i   in   valid/ready   disk_index, used/reserved/capacity bytes
//   result_o   out  valid/ready   disk_echo, is_pressured, has_deficit,
//                                 deficit_bytes
//   cfg        in   cfg_we_i      cfg_idx_i, cfg_data_i (no read-back)
//
// One report per cycle once the sweep is done and while no result stalls;
// forwarded flag writes keep the read-modify-write from limiting that rate.
// After reset the flag memory is swept clear, one entry per cycle, over all
// min(DISK_COUNT, 64) entries; report_i.ready is low meanwhile.
// A stalled result holds the whole pipeline.
// ----------------------------------------------------------------------------
module disk_watermark_pressure_tracker #(
  parameter int DISK_COUNT = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dwpt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dwpt_pkg::CFG_W-1:0]     cfg_data_i,
  dwpt_report_if.sink                    report_i,
  dwpt_result_if.source                  result_o
);

  localparam int DEPTH = (DISK_COUNT < (1 << dwpt_pkg::DISK_W)) ?
                         DISK_COUNT : (1 << dwpt_pkg::DISK_W);

  logic [dwpt_pkg::WM_W-1:0] high_wm_q, low_wm_q;

  logic adv, accept, busy;

  logic                         s1_valid_q, s1_inr_q;
  logic [dwpt_pkg::DISK_W-1:0]  s1_disk_q;
  logic [dwpt_pkg::BYTES_W-1:0] s1_used_q, s1_rsv_q;
  logic [dwpt_pkg::BYTES_W:0]   s1_sum;
  logic [dwpt_pkg::BYTES_W-1:0] s1_usage, high_mark, low_mark;
  logic                         s1_flag;

  logic                         s2_valid_q, s2_inr_q, s2_flag_q;
  logic [dwpt_pkg::DISK_W-1:0]  s2_disk_q;
  logic [dwpt_pkg::BYTES_W-1:0] s2_usage_q, s2_high_q, s2_low_q;
  logic                         s2_new_flag, s2_deficit;
  dwpt_pkg::flag_wr_t           s2_wr;

  logic                         out_valid_q, out_flag_q, out_def_q;
  logic [dwpt_pkg::DISK_W-1:0]  out_disk_q;
  logic [dwpt_pkg::BYTES_W-1:0] out_amount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_wm_q <= dwpt_pkg::HIGH_WM_RST;
      low_wm_q  <= dwpt_pkg::LOW_WM_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dwpt_pkg::CFG_HIGH_WM) begin
        high_wm_q <= cfg_data_i;
      end
      if (cfg_idx_i == dwpt_pkg::CFG_LOW_WM) begin
        low_wm_q <= cfg_data_i;
      end
    end
  end

  assign adv            = !out_valid_q || result_o.ready;
  assign report_i.ready = adv && !busy;
  assign accept         = report_i.valid && report_i.ready;

  dwpt_mark_unit u_mark (
    .clk_i       (clk_i),
    .en_i        (accept),
    .cap_i       (report_i.capacity_bytes),
    .high_wm_i   (high_wm_q),
    .low_wm_i    (low_wm_q),
    .high_mark_o (high_mark),
    .low_mark_o  (low_mark)
  );

  dwpt_flag_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .rd_en_i   (accept),
    .rd_disk_i (report_i.disk_index),
    .s1_disk_i (s1_disk_q),
    .wr_i      (s2_wr),
    .flag_o    (s1_flag),
    .busy_o    (busy)
  );

  // stage 1: saturating usage, marks, forwarded flag
  assign s1_sum   = {1'b0, s1_used_q} + {1'b0, s1_rsv_q};
  assign s1_usage = s1_sum[dwpt_pkg::BYTES_W] ? '1 : s1_sum[dwpt_pkg::BYTES_W-1:0];

  // stage 2: hysteresis and deficit
  always_comb begin
    if (s2_flag_q) begin
      s2_new_flag = !(s2_usage_q < s2_low_q);
    end else begin
      s2_new_flag = (s2_usage_q >= s2_high_q);
    end
    s2_deficit = s2_inr_q && s2_new_flag && (s2_usage_q >= s2_low_q);
    s2_wr.en   = s2_valid_q && s2_inr_q;
    s2_wr.disk = s2_disk_q;
    s2_wr.flag = s2_new_flag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_disk_q    <= report_i.disk_index;
      s1_inr_q     <= (32'(report_i.disk_index) < DISK_COUNT);
      s1_used_q    <= report_i.used_bytes;
      s1_rsv_q     <= report_i.reserved_bytes;
      s2_disk_q    <= s1_disk_q;
      s2_inr_q     <= s1_inr_q;
      s2_usage_q   <= s1_usage;
      s2_high_q    <= high_mark;
      s2_low_q     <= low_mark;
      s2_flag_q    <= s1_flag;
      out_disk_q   <= s2_disk_q;
      out_flag_q   <= s2_inr_q && s2_new_flag;
      out_def_q    <= s2_deficit;
      out_amount_q <= s2_deficit ? (s2_usage_q - s2_low_q + 64'd1) : '0;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.disk_echo     = out_disk_q;
  assign result_o.is_pressured  = out_flag_q;
  assign result_o.has_deficit   = out_def_q;
  assign result_o.deficit_bytes = out_amount_q;

endmodule

FILE: src/dwpt_checker.sv
// ----------------------------------------------------------------------------
// dwpt_checker
// Port-level checks of the pressure tracker, bound to the top level.
// ----------------------------------------------------------------------------
module dwpt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [dwpt_pkg::DISK_W-1:0]  res_disk,
  input logic                         res_flag,
  input logic                         res_def,
  input logic [dwpt_pkg::BYTES_W-1:0] res_amount
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_disk) &&
      $stable(res_flag) && $stable(res_def) && $stable(res_amount))
    else $error("result changed while stalled");

  a_def_needs_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_def |-> res_flag)
    else $error("deficit reported on unpressured disk");

  a_no_def_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_def |-> res_amount == '0)
    else $error("nonzero amount without deficit");

  a_def_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_def |-> res_amount != '0)
    else $error("zero amount with deficit");

endmodule

bind disk_watermark_pressure_tracker dwpt_checker u_dwpt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .res_valid  (result_o.valid),
  .res_ready  (result_o.ready),
  .res_disk   (result_o.disk_echo),
  .res_flag   (result_o.is_pressured),
  .res_def    (result_o.has_deficit),
  .res_amount (result_o.deficit_bytes)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the disk watermark pressure tracker. Space reports
// go in through a queue-fed driver; a monitor compares every result against
// per-disk hysteresis flags tracked in the bench, over several watermark
// settings and with random idling and long result stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DISK_W    = dwpt_pkg::DISK_W;
  localparam int BYTES_W   = dwpt_pkg::BYTES_W;
  localparam int WM_W      = dwpt_pkg::WM_W;
  localparam int CFG_IDX_W = dwpt_pkg::CFG_IDX_W;
  localparam int CFG_W     = dwpt_pkg::CFG_W;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WM = dwpt_pkg::CFG_HIGH_WM;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_WM  = dwpt_pkg::CFG_LOW_WM;
  localparam logic [WM_W-1:0]      HIGH_WM_RST = dwpt_pkg::HIGH_WM_RST;
  localparam logic [WM_W-1:0]      LOW_WM_RST  = dwpt_pkg::LOW_WM_RST;

  localparam int DISK_COUNT       = 64;
  localparam int PIPE_LATENCY     = 3;
  localparam int QUIET_LIMIT      = 1000;
  localparam int RANDOM_PER_PHASE = 210;
  localparam int LONG_HOLD        = 60;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [DISK_W-1:0]  disk;
    logic [BYTES_W-1:0] used;
    logic [BYTES_W-1:0] reserved;
    logic [BYTES_W-1:0] capacity;
  } space_report_t;

  typedef struct packed {
    logic [DISK_W-1:0]  disk_echo;
    logic               is_pressured;
    logic               has_deficit;
    logic [BYTES_W-1:0] deficit_bytes;
  } pressure_verdict_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  dwpt_report_if report_if ();
  dwpt_result_if result_if ();

  disk_watermark_pressure_tracker #(
    .DISK_COUNT (DISK_COUNT)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .report_i   (report_if),
    .result_o   (result_if)
  );

  always #1ns clk_i = ~clk_i;

  // bench copy of the block state
  logic [WM_W-1:0]       high_wm;
  logic [WM_W-1:0]       low_wm;
  logic [DISK_COUNT-1:0] pressured;
  logic [BYTES_W-1:0]    disk_cap [DISK_COUNT];

  space_report_t     report_q [$];
  pressure_verdict_t verdict_q [$];
  space_report_t     on_offer;

  int reports_queued = 0;
  int reports_taken  = 0;
  int results_seen   = 0;
  int n_errors       = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  function automatic logic [BYTES_W-1:0] random_bytes();
    return {$urandom, $urandom};
  endfunction

  // floor(cap * frac / 2^16), at least 1
  function automatic logic [BYTES_W-1:0] fill_mark(logic [BYTES_W-1:0] cap,
                                                   logic [WM_W-1:0] frac);
    logic [BYTES_W+WM_W-1:0] prod;
    prod = cap * frac;
    if (prod[BYTES_W+WM_W-1:WM_W] == '0) begin
      return 64'd1;
    end
    return prod[BYTES_W+WM_W-1:WM_W];
  endfunction

  function automatic pressure_verdict_t update_pressure(space_report_t r);
    pressure_verdict_t v;
    logic [BYTES_W:0]   sum;
    logic [BYTES_W-1:0] usage;
    logic [BYTES_W-1:0] hi_mark;
    logic [BYTES_W-1:0] lo_mark;
    logic               flag;
    sum     = {1'b0, r.used} + {1'b0, r.reserved};
    usage   = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
    hi_mark = fill_mark(r.capacity, high_wm);
    lo_mark = fill_mark(r.capacity, low_wm);
    v = '{disk_echo: r.disk, is_pressured: 1'b0, has_deficit: 1'b0, deficit_bytes: '0};
    if (r.disk < DISK_COUNT) begin
      flag = pressured[r.disk];
      if (flag) begin
        flag = (usage >= lo_mark);
      end else begin
        flag = (usage >= hi_mark);
      end
      pressured[r.disk] = flag;
      v.is_pressured = flag;
      if (flag && usage >= lo_mark) begin
        v.has_deficit   = 1'b1;
        v.deficit_bytes = usage - (lo_mark - 64'd1);
      end
    end
    return v;
  endfunction

  function automatic logic [BYTES_W-1:0] pick_capacity();
    case ($urandom_range(0, 4))
      0: begin
        return 64'($urandom_range(0, 40));
      end
      1: begin
        return {32'd0, $urandom};
      end
      2: begin
        return '1;
      end
      default: begin
        return random_bytes();
      end
    endcase
  endfunction

  task automatic log_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic queue_report(logic [DISK_W-1:0] d, logic [BYTES_W-1:0] u,
                              logic [BYTES_W-1:0] r, logic [BYTES_W-1:0] c);
    space_report_t item;
    item     = '{disk: d, used: u, reserved: r, capacity: c};
    report_q = {report_q, item};
    reports_queued++;
  endtask

  // mostly usage placed around the marks of a per-disk capacity, some noise
  task automatic queue_random_report();
    logic [DISK_W-1:0]  d;
    logic [BYTES_W-1:0] cap;
    logic [BYTES_W-1:0] hi;
    logic [BYTES_W-1:0] lo;
    logic [BYTES_W-1:0] base;
    logic [BYTES_W-1:0] span;
    logic [BYTES_W-1:0] u;
    logic [BYTES_W-1:0] r;
    d = ($urandom_range(0, 99) < 40) ? DISK_W'($urandom_range(0, 3)) :
                                       DISK_W'($urandom_range(0, DISK_COUNT - 1));
    if ($urandom_range(0, 99) < 10) begin
      queue_report(d, random_bytes(), random_bytes(), random_bytes());
      return;
    end
    if ($urandom_range(0, 99) < 8) begin
      disk_cap[d] = pick_capacity();
    end
    cap  = disk_cap[d];
    hi   = fill_mark(cap, high_wm);
    lo   = fill_mark(cap, low_wm);
    base = (hi < lo) ? hi : lo;
    span = (hi < lo) ? lo - hi : hi - lo;
    case ($urandom_range(0, 11))
      0:       u = lo - 64'd1;
      1:       u = lo;
      2:       u = lo + 64'd1;
      3:       u = hi - 64'd1;
      4:       u = hi;
      5:       u = hi + 64'd1;
      8:       u = '0;
      9:       u = '1;
      10:      u = random_bytes();
      11:      u = hi + 64'($urandom_range(0, 1000));
      default: u = base + random_bytes() % (span + 64'd1);
    endcase
    case ($urandom_range(0, 9))
      0: begin
        queue_report(d, random_bytes() | {1'b1, 63'd0}, random_bytes() | {1'b1, 63'd0}, cap);
      end
      1, 2: begin
        queue_report(d, u, '0, cap);
      end
      3: begin
        queue_report(d, '0, u, cap);
      end
      default: begin
        r = (u == '1) ? random_bytes() : random_bytes() % (u + 64'd1);
        queue_report(d, u - r, r, cap);
      end
    endcase
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_HIGH_WM) begin
      high_wm = data;
    end else if (idx == CFG_LOW_WM) begin
      low_wm = data;
    end
  endtask

  task automatic wait_idle();
    while (reports_taken != reports_queued || verdict_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // report driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      report_if.valid <= 1'b0;
    end else begin
      if (report_if.valid && report_if.ready) begin
        verdict_q = {verdict_q, update_pressure(on_offer)};
        reports_taken++;
      end
      if (!report_if.valid || report_if.ready) begin
        if (report_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_offer = report_q.pop_front();
          report_if.valid          <= 1'b1;
          report_if.disk_index     <= on_offer.disk;
          report_if.used_bytes     <= on_offer.used;
          report_if.reserved_bytes <= on_offer.reserved;
          report_if.capacity_bytes <= on_offer.capacity;
        end else begin
          report_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    pressure_verdict_t want;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          log_mismatch($sformatf("unexpected result for disk %0d", result_if.disk_echo));
        end else begin
          want = verdict_q.pop_front();
          if (result_if.disk_echo !== want.disk_echo)
            log_mismatch($sformatf("disk_echo %0d, want %0d",
                                   result_if.disk_echo, want.disk_echo));
          if (result_if.is_pressured !== want.is_pressured)
            log_mismatch($sformatf("disk %0d is_pressured %b, want %b", want.disk_echo,
                                   result_if.is_pressured, want.is_pressured));
          if (result_if.has_deficit !== want.has_deficit)
            log_mismatch($sformatf("disk %0d has_deficit %b, want %b", want.disk_echo,
                                   result_if.has_deficit, want.has_deficit));
          if (result_if.deficit_bytes !== want.deficit_bytes)
            log_mismatch($sformatf("disk %0d deficit_bytes %0h, want %0h", want.disk_echo,
                                   result_if.deficit_bytes, want.deficit_bytes));
        end
        // long back-pressure so the pipeline fills and stalls its input
        if (results_seen == 150 || results_seen == 900) begin
          hold_left = LONG_HOLD;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on transactions
  always @(posedge clk_i) begin
    if ((report_if.valid && report_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** disk_watermark_pressure_tracker: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [BYTES_W-1:0] cap;
    logic [BYTES_W-1:0] hi;
    logic [BYTES_W-1:0] lo;
    logic [WM_W-1:0]    h;
    logic [WM_W-1:0]    l;
    rst_ni                   = 1'b0;
    cfg_we_i                 = 1'b0;
    cfg_idx_i                = '0;
    cfg_data_i               = '0;
    report_if.valid          = 1'b0;
    report_if.disk_index     = '0;
    report_if.used_bytes     = '0;
    report_if.reserved_bytes = '0;
    report_if.capacity_bytes = '0;
    result_if.ready          = 1'b0;
    pressured                = '0;
    high_wm                  = HIGH_WM_RST;
    low_wm                   = LOW_WM_RST;
    foreach (disk_cap[i]) disk_cap[i] = pick_capacity();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset watermarks
    cap = 64'd1000;
    hi  = fill_mark(cap, high_wm);
    lo  = fill_mark(cap, low_wm);
    queue_report(6'd0, '0, '0, cap);
    queue_report(6'd0, hi - 64'd2, 64'd1, cap);
    queue_report(6'd0, hi - 64'd1, 64'd1, cap);
    queue_report(6'd0, '0, lo, cap);
    queue_report(6'd0, lo - 64'd1, '0, cap);
    queue_report(6'd0, lo, '0, cap);
    queue_report(6'd63, '1, '1, '1);
    queue_report(6'd63, {1'b1, 63'd0}, {1'b1, 63'd0}, '1);
    queue_report(6'd63, 64'hFFFF_FFFF_FFFF_FFFE, 64'd1, '1);
    queue_report(6'd63, '0, '0, '0);
    queue_report(6'd1, 64'd1, '0, '0);
    queue_report(6'd1, '0, 64'd1, 64'd1);
    queue_report(6'd2, '1, '0, 64'd5);
    queue_report(6'd2, '0, '0, 64'd5);
    queue_report(6'd3, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, '1);
    wait_idle();

    // widest hysteresis; writes past the register map must not land
    program_reg(CFG_HIGH_WM, 16'hFFFF);
    program_reg(CFG_LOW_WM, 16'h0001);
    program_reg(CFG_SPARE_A, 16'h0000);
    program_reg(CFG_SPARE_B, 16'hA5A5);
    queue_report(6'd4, '1, '0, '1);
    queue_report(6'd4, '0, '0, '1);
    queue_report(6'd4, 64'd1, '0, 64'd3);
    wait_idle();

    // zero watermarks: both marks forced to 1
    program_reg(CFG_HIGH_WM, 16'h0000);
    program_reg(CFG_LOW_WM, 16'h0000);
    queue_report(6'd5, '0, '0, '1);
    queue_report(6'd5, 64'd1, '0, '1);
    queue_report(6'd5, '0, '0, '1);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       begin h = HIGH_WM_RST; l = LOW_WM_RST;  end
        1:       begin h = 16'd65535;   l = 16'd1;       end
        2:       begin h = 16'd1;       l = 16'd65534;   end
        3:       begin h = 16'd32768;   l = 16'd16384;   end
        4:       begin h = 16'd0;       l = 16'd65535;   end
        default: begin h = 16'd60000;   l = 16'd45000;   end
      endcase
      wait_idle();
      program_reg(CFG_HIGH_WM, h);
      program_reg(CFG_LOW_WM, l);
      send_idle_pct = (p < 2) ? 30 : (p < 4) ? 70 : 0;
      recv_idle_pct = (p < 2) ? 70 : (p < 4) ? 30 : 0;
      repeat (RANDOM_PER_PHASE) queue_random_report();
    end
    wait_idle();

    if (n_errors == 0) begin
      $display("** disk_watermark_pressure_tracker: PASSED **");
    end else begin
      $display("** disk_watermark_pressure_tracker: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/dwpt_pkg.sv
src/dwpt_report_if.sv
src/dwpt_result_if.sv
src/dwpt_mark_unit.sv
src/dwpt_flag_store.sv
src/disk_watermark_pressure_tracker.sv
src/dwpt_checker.sv
tb/tb_top.sv
